>>> hdl/tfhp_pkg.sv
// Shared types and codes for the frame header parser.
// No dependencies; every other file imports this package.
package tfhp_pkg;

    localparam logic [7:0] VERSION_RESET = 8'd5;
    localparam logic [6:0] TOKEN_RESET   = 7'd32;
    localparam logic [7:0] UUID_BYTES    = 8'd16;
    localparam logic [7:0] IPV4_BYTES    = 8'd4;
    localparam logic [7:0] IPV6_BYTES    = 8'd16;

    localparam logic [7:0] CMD_AUTH      = 8'd0;
    localparam logic [7:0] CMD_CONNECT   = 8'd1;
    localparam logic [7:0] CMD_PACKET    = 8'd2;
    localparam logic [7:0] CMD_DISSOC    = 8'd3;
    localparam logic [7:0] CMD_HEARTBEAT = 8'd4;

    localparam logic [7:0] AT_DOMAIN = 8'd0;
    localparam logic [7:0] AT_IPV4   = 8'd1;
    localparam logic [7:0] AT_IPV6   = 8'd2;
    localparam logic [7:0] AT_NONE   = 8'd255;

    // configuration register indexes
    localparam logic CFG_VERSION = 1'b0;
    localparam logic CFG_TOKEN   = 1'b1;

    typedef enum logic [3:0] {
        PH_VER, PH_CMD, PH_UUID, PH_TOKEN, PH_ASSOC, PH_PKTID, PH_FRAGTOT,
        PH_FRAGID, PH_SIZE, PH_ATYP, PH_DOMLEN, PH_ADDR, PH_PORT, PH_PAYLOAD,
        PH_DONE, PH_IGNORE
    } t_phase;

    typedef enum logic [3:0] {
        ROLE_VER, ROLE_CMD, ROLE_UUID, ROLE_TOKEN, ROLE_ASSOC, ROLE_PKTID,
        ROLE_FRAGTOT, ROLE_FRAGID, ROLE_SIZE, ROLE_ATYP, ROLE_DOMLEN,
        ROLE_ADDR, ROLE_PORT, ROLE_PAYLOAD, ROLE_IGNORE
    } t_role;

    typedef enum logic [2:0] {
        ST_OK, ST_TRUNC, ST_BAD_VER, ST_BAD_CMD, ST_BAD_ATYP, ST_ZERO_DOM
    } t_status;

    typedef struct packed {
        t_role       byte_role;
        logic [7:0]  byte_value;
        logic        verdict_valid;
        t_status     status;
        logic [7:0]  command_code;
        logic [15:0] assoc_num;
        logic [15:0] packet_id;
        logic [7:0]  frag_count;
        logic [7:0]  frag_id;
        logic [15:0] data_size;
        logic [15:0] port;
        logic [9:0]  header_length;
    } t_result;

endpackage

>>> hdl/tfhp_if.sv
// Channel interfaces for the frame header parser: byte input and result output.
// Depends on tfhp_pkg for the role and status types.
interface tfhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tfhp_out_if import tfhp_pkg::*;;
    logic        valid;
    logic        ready;
    t_role       byte_role;
    logic [7:0]  byte_value;
    logic        verdict_valid;
    t_status     status;
    logic [7:0]  command_code;
    logic [15:0] assoc_num;
    logic [15:0] packet_id;
    logic [7:0]  frag_count;
    logic [7:0]  frag_id;
    logic [15:0] data_size;
    logic [15:0] port;
    logic [9:0]  header_length;

    modport source (
        output valid, output byte_role, output byte_value, output verdict_valid,
        output status, output command_code, output assoc_num, output packet_id,
        output frag_count, output frag_id, output data_size, output port,
        output header_length, input ready
    );
    modport sink (
        input valid, input byte_role, input byte_value, input verdict_valid,
        input status, input command_code, input assoc_num, input packet_id,
        input frag_count, input frag_id, input data_size, input port,
        input header_length, output ready
    );
endinterface

>>> hdl/tuic_frame_header_parser.sv
// Frame header parser: takes one frame byte per item and returns one result per byte,
// its role and, on the final byte of a buffer, a status with the decoded header fields.
// Depends on tfhp_pkg and the channel interfaces in tfhp_if.sv.
//
// The parser sustains one byte per clock while results are taken. Each byte passes an
// input register and then a result register, from which its result is offered; the
// frame state updates as the byte moves from the input register to the result register.
// Both registers are single-entry and step independently, so a stalled result still lets
// one more byte into the input register, and the input stalls only while both are full
// and the result is not taken. The first error of a frame is latched; all frame state
// clears after the byte flagged last. Configuration writes (version value, token length)
// take effect at once and belong between frames.
module tuic_frame_header_parser
    import tfhp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    tfhp_in_if.sink    i_in,
    tfhp_out_if.source o_out
);

    // configuration
    logic [7:0] r_ver;
    logic [6:0] r_tok;

    // input stage
    logic       r_in_vld;
    logic [7:0] r_in_data;
    logic       r_in_last;

    // result stage
    logic    r_out_vld;
    t_result r_out;
    t_result n_out;

    // frame state
    t_phase      r_phase,  n_phase;
    logic [7:0]  r_fcnt,   n_fcnt;
    logic [7:0]  r_cmd,    n_cmd;
    logic [15:0] r_assoc,  n_assoc;
    logic [15:0] r_pktid,  n_pktid;
    logic [7:0]  r_ftot,   n_ftot;
    logic [7:0]  r_fid,    n_fid;
    logic [15:0] r_size,   n_size;
    logic [15:0] r_port,   n_port;
    logic [9:0]  r_hcnt,   n_hcnt;
    logic [16:0] r_pcnt,   n_pcnt;
    t_status     r_err,    n_err;

    logic    advance;
    logic    fld_end;
    logic [7:0] fcnt_dec;
    logic    fail_req;
    t_status fail_code;
    t_role   role;
    logic [7:0] b;

    assign advance    = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || advance;
    assign b          = r_in_data;
    assign fld_end    = (r_fcnt <= 8'd1);
    assign fcnt_dec   = fld_end ? 8'd0 : r_fcnt - 8'd1;

    always_comb begin
        n_phase   = r_phase;
        n_fcnt    = r_fcnt;
        n_cmd     = r_cmd;
        n_assoc   = r_assoc;
        n_pktid   = r_pktid;
        n_ftot    = r_ftot;
        n_fid     = r_fid;
        n_size    = r_size;
        n_port    = r_port;
        n_hcnt    = r_hcnt;
        n_pcnt    = r_pcnt;
        n_err     = r_err;
        fail_req  = 1'b0;
        fail_code = ST_OK;
        role      = ROLE_IGNORE;

        case (r_phase)
            PH_VER: begin
                role = ROLE_VER;
                if (b != r_ver) begin
                    fail_req  = 1'b1;
                    fail_code = ST_BAD_VER;
                end else begin
                    n_phase = PH_CMD;
                    n_fcnt  = 8'd0;
                end
            end
            PH_CMD: begin
                role  = ROLE_CMD;
                n_cmd = b;
                n_fcnt = 8'd0;
                if (b == CMD_AUTH) begin
                    n_phase = PH_UUID;
                    n_fcnt  = UUID_BYTES;
                end else if (b == CMD_CONNECT) begin
                    n_phase = PH_ATYP;
                end else if (b == CMD_PACKET || b == CMD_DISSOC) begin
                    n_phase = PH_ASSOC;
                    n_fcnt  = 8'd2;
                end else if (b == CMD_HEARTBEAT) begin
                    n_phase = PH_DONE;
                end else begin
                    n_fcnt    = r_fcnt;
                    fail_req  = 1'b1;
                    fail_code = ST_BAD_CMD;
                end
            end
            PH_UUID: begin
                role   = ROLE_UUID;
                n_fcnt = fcnt_dec;
                if (fld_end) begin
                    if (r_tok != 7'd0) begin
                        n_phase = PH_TOKEN;
                        n_fcnt  = {1'b0, r_tok};
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
            end
            PH_TOKEN: begin
                role   = ROLE_TOKEN;
                n_fcnt = fcnt_dec;
                if (fld_end) begin
                    n_phase = PH_DONE;
                end
            end
            PH_ASSOC: begin
                role    = ROLE_ASSOC;
                n_assoc = {r_assoc[7:0], b};
                n_fcnt  = fcnt_dec;
                if (fld_end) begin
                    if (r_cmd == CMD_PACKET) begin
                        n_phase = PH_PKTID;
                        n_fcnt  = 8'd2;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
            end
            PH_PKTID: begin
                role    = ROLE_PKTID;
                n_pktid = {r_pktid[7:0], b};
                n_fcnt  = fcnt_dec;
                if (fld_end) begin
                    n_phase = PH_FRAGTOT;
                end
            end
            PH_FRAGTOT: begin
                role    = ROLE_FRAGTOT;
                n_ftot  = b;
                n_phase = PH_FRAGID;
                n_fcnt  = 8'd0;
            end
            PH_FRAGID: begin
                role    = ROLE_FRAGID;
                n_fid   = b;
                n_phase = PH_SIZE;
                n_fcnt  = 8'd2;
            end
            PH_SIZE: begin
                role   = ROLE_SIZE;
                n_size = {r_size[7:0], b};
                n_fcnt = fcnt_dec;
                if (fld_end) begin
                    n_phase = PH_ATYP;
                end
            end
            PH_ATYP: begin
                role   = ROLE_ATYP;
                n_fcnt = 8'd0;
                if (b == AT_DOMAIN) begin
                    n_phase = PH_DOMLEN;
                end else if (b == AT_IPV4) begin
                    n_phase = PH_ADDR;
                    n_fcnt  = IPV4_BYTES;
                end else if (b == AT_IPV6) begin
                    n_phase = PH_ADDR;
                    n_fcnt  = IPV6_BYTES;
                end else if (b == AT_NONE && r_cmd == CMD_PACKET) begin
                    // no address: payload follows the header directly
                    n_phase = (r_size != 16'd0) ? PH_PAYLOAD : PH_DONE;
                end else begin
                    n_fcnt    = r_fcnt;
                    fail_req  = 1'b1;
                    fail_code = ST_BAD_ATYP;
                end
            end
            PH_DOMLEN: begin
                role = ROLE_DOMLEN;
                if (b == 8'd0) begin
                    fail_req  = 1'b1;
                    fail_code = ST_ZERO_DOM;
                end else begin
                    n_phase = PH_ADDR;
                    n_fcnt  = b;
                end
            end
            PH_ADDR: begin
                role   = ROLE_ADDR;
                n_fcnt = fcnt_dec;
                if (fld_end) begin
                    n_phase = PH_PORT;
                    n_fcnt  = 8'd2;
                end
            end
            PH_PORT: begin
                role   = ROLE_PORT;
                n_port = {r_port[7:0], b};
                n_fcnt = fcnt_dec;
                if (fld_end) begin
                    n_phase = (r_cmd == CMD_PACKET && r_size != 16'd0) ? PH_PAYLOAD : PH_DONE;
                    n_fcnt  = 8'd0;
                end
            end
            PH_PAYLOAD: begin
                role   = ROLE_PAYLOAD;
                n_pcnt = r_pcnt + 17'd1;
                if (n_pcnt >= {1'b0, r_size}) begin
                    n_phase = PH_DONE;
                    n_fcnt  = 8'd0;
                end
            end
            default: begin
                role = ROLE_IGNORE;
            end
        endcase

        // first error wins
        if (fail_req) begin
            n_phase = PH_IGNORE;
            if (r_err == ST_OK) begin
                n_err = fail_code;
            end
        end

        if (role != ROLE_PAYLOAD && role != ROLE_IGNORE) begin
            n_hcnt = r_hcnt + 10'd1;
        end

        n_out               = '0;
        n_out.byte_role     = role;
        n_out.byte_value    = b;
        if (r_in_last) begin
            n_out.verdict_valid = 1'b1;
            if (n_err != ST_OK) begin
                n_out.status = n_err;
            end else if (n_phase != PH_DONE) begin
                n_out.status = ST_TRUNC;
            end else begin
                n_out.status = ST_OK;
            end
            n_out.command_code  = n_cmd;
            n_out.assoc_num     = n_assoc;
            n_out.packet_id     = n_pktid;
            n_out.frag_count    = n_ftot;
            n_out.frag_id       = n_fid;
            n_out.data_size     = n_size;
            n_out.port          = n_port;
            n_out.header_length = n_hcnt;

            // start a new frame
            n_phase = PH_VER;
            n_fcnt  = 8'd0;
            n_cmd   = 8'd0;
            n_assoc = 16'd0;
            n_pktid = 16'd0;
            n_ftot  = 8'd0;
            n_fid   = 8'd0;
            n_size  = 16'd0;
            n_port  = 16'd0;
            n_hcnt  = 10'd0;
            n_pcnt  = 17'd0;
            n_err   = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ver     <= VERSION_RESET;
            r_tok     <= TOKEN_RESET;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_phase   <= PH_VER;
            r_fcnt    <= 8'd0;
            r_cmd     <= 8'd0;
            r_assoc   <= 16'd0;
            r_pktid   <= 16'd0;
            r_ftot    <= 8'd0;
            r_fid     <= 8'd0;
            r_size    <= 16'd0;
            r_port    <= 16'd0;
            r_hcnt    <= 10'd0;
            r_pcnt    <= 17'd0;
            r_err     <= ST_OK;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_VERSION) begin
                    r_ver <= i_cfg_data;
                end else if (i_cfg_idx == CFG_TOKEN) begin
                    r_tok <= i_cfg_data[6:0];
                end
            end

            if (i_in.valid && i_in.ready) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end

            if (advance) begin
                r_out_vld <= 1'b1;
                r_phase   <= n_phase;
                r_fcnt    <= n_fcnt;
                r_cmd     <= n_cmd;
                r_assoc   <= n_assoc;
                r_pktid   <= n_pktid;
                r_ftot    <= n_ftot;
                r_fid     <= n_fid;
                r_size    <= n_size;
                r_port    <= n_port;
                r_hcnt    <= n_hcnt;
                r_pcnt    <= n_pcnt;
                r_err     <= n_err;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_data <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.byte_role     = r_out.byte_role;
    assign o_out.byte_value    = r_out.byte_value;
    assign o_out.verdict_valid = r_out.verdict_valid;
    assign o_out.status        = r_out.status;
    assign o_out.command_code  = r_out.command_code;
    assign o_out.assoc_num     = r_out.assoc_num;
    assign o_out.packet_id     = r_out.packet_id;
    assign o_out.frag_count    = r_out.frag_count;
    assign o_out.frag_id       = r_out.frag_id;
    assign o_out.data_size     = r_out.data_size;
    assign o_out.port          = r_out.port;
    assign o_out.header_length = r_out.header_length;

`ifndef SYNTHESIS
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> r_phase == PH_VER && r_err == ST_OK && r_hcnt == 10'd0)
        else $error("frame state not cleared after final byte");

    a_err_ignores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err != ST_OK |-> r_phase == PH_IGNORE)
        else $error("latched error outside ignore phase");

    a_no_verdict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out.verdict_valid |-> r_out.status == ST_OK && r_out.header_length == 10'd0)
        else $error("fields driven without verdict");

    a_ver_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_VER |-> r_hcnt == 10'd0 && r_fcnt == 8'd0)
        else $error("stale counters at frame start");
`endif

endmodule

>>> verif/tuic_frame_header_parser_tb.sv
// Self-checking testbench for tuic_frame_header_parser: random and directed frames go in
// byte by byte, every result is compared with a built-in frame decoder.
// Depends on tfhp_pkg and the channel interfaces of tfhp_if.sv.
module tuic_frame_header_parser_tb;
    import tfhp_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int LONG_HOLD   = 150;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_frame_byte;

    typedef enum {PRESS_NONE, PRESS_HOLD, PRESS_PAUSE} t_pressure;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [7:0] i_cfg_data;

    tfhp_in_if  in_ch();
    tfhp_out_if out_ch();

    tuic_frame_header_parser DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    t_frame_byte pending_bytes[$];
    t_result     expected_results[$];
    logic [7:0]  frame_buf[$];
    t_result     oldest;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asks      = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int fault_count    = 0;
    int results_seen   = 0;
    int verdicts_seen  = 0;
    int bytes_sent     = 0;
    int frames_built   = 0;

    // decoder state and its copy of the registers
    logic [7:0]  ver_cfg;
    logic [6:0]  tok_cfg;
    t_phase      dec_phase;
    logic [7:0]  dec_left;
    logic [7:0]  dec_cmd;
    logic [15:0] dec_assoc;
    logic [15:0] dec_pktid;
    logic [7:0]  dec_ftot;
    logic [7:0]  dec_fid;
    logic [15:0] dec_size;
    logic [15:0] dec_port;
    logic [9:0]  dec_hdr;
    logic [16:0] dec_paid;
    t_status     dec_err;

    function automatic void clear_frame_state();
        dec_phase = PH_VER;
        dec_left  = '0;
        dec_cmd   = '0;
        dec_assoc = '0;
        dec_pktid = '0;
        dec_ftot  = '0;
        dec_fid   = '0;
        dec_size  = '0;
        dec_port  = '0;
        dec_hdr   = '0;
        dec_paid  = '0;
        dec_err   = ST_OK;
    endfunction

    function automatic void move_to(input t_phase nxt, input logic [7:0] count);
        dec_phase = nxt;
        dec_left  = count;
    endfunction

    // keep the first error of the frame, ignore the rest of it
    function automatic void latch_error(input t_status code);
        if (dec_err == ST_OK) begin
            dec_err = code;
        end
        dec_phase = PH_IGNORE;
    endfunction

    function automatic bit field_last();
        if (dec_left <= 8'd1) begin
            dec_left = '0;
            return 1'b1;
        end
        dec_left = dec_left - 8'd1;
        return 1'b0;
    endfunction

    function automatic void address_done();
        if (dec_cmd == CMD_PACKET && dec_size != 16'd0) begin
            move_to(PH_PAYLOAD, 8'd0);
        end else begin
            move_to(PH_DONE, 8'd0);
        end
    endfunction

    function automatic t_result decode_byte(input logic [7:0] b, input logic last_flag);
        t_role   role;
        t_result r;
        role = ROLE_IGNORE;
        case (dec_phase)
            PH_VER: begin
                role = ROLE_VER;
                if (b != ver_cfg) latch_error(ST_BAD_VER);
                else move_to(PH_CMD, 8'd0);
            end
            PH_CMD: begin
                role = ROLE_CMD;
                dec_cmd = b;
                if (b == CMD_AUTH) move_to(PH_UUID, UUID_BYTES);
                else if (b == CMD_CONNECT) move_to(PH_ATYP, 8'd0);
                else if (b == CMD_PACKET || b == CMD_DISSOC) move_to(PH_ASSOC, 8'd2);
                else if (b == CMD_HEARTBEAT) move_to(PH_DONE, 8'd0);
                else latch_error(ST_BAD_CMD);
            end
            PH_UUID: begin
                role = ROLE_UUID;
                if (field_last()) begin
                    if (tok_cfg != 7'd0) move_to(PH_TOKEN, {1'b0, tok_cfg});
                    else move_to(PH_DONE, 8'd0);
                end
            end
            PH_TOKEN: begin
                role = ROLE_TOKEN;
                if (field_last()) move_to(PH_DONE, 8'd0);
            end
            PH_ASSOC: begin
                role = ROLE_ASSOC;
                dec_assoc = {dec_assoc[7:0], b};
                if (field_last()) begin
                    if (dec_cmd == CMD_PACKET) move_to(PH_PKTID, 8'd2);
                    else move_to(PH_DONE, 8'd0);
                end
            end
            PH_PKTID: begin
                role = ROLE_PKTID;
                dec_pktid = {dec_pktid[7:0], b};
                if (field_last()) move_to(PH_FRAGTOT, 8'd0);
            end
            PH_FRAGTOT: begin
                role = ROLE_FRAGTOT;
                dec_ftot = b;
                move_to(PH_FRAGID, 8'd0);
            end
            PH_FRAGID: begin
                role = ROLE_FRAGID;
                dec_fid = b;
                move_to(PH_SIZE, 8'd2);
            end
            PH_SIZE: begin
                role = ROLE_SIZE;
                dec_size = {dec_size[7:0], b};
                if (field_last()) move_to(PH_ATYP, 8'd0);
            end
            PH_ATYP: begin
                role = ROLE_ATYP;
                if (b == AT_DOMAIN) move_to(PH_DOMLEN, 8'd0);
                else if (b == AT_IPV4) move_to(PH_ADDR, IPV4_BYTES);
                else if (b == AT_IPV6) move_to(PH_ADDR, IPV6_BYTES);
                else if (b == AT_NONE && dec_cmd == CMD_PACKET) address_done();
                else latch_error(ST_BAD_ATYP);
            end
            PH_DOMLEN: begin
                role = ROLE_DOMLEN;
                if (b == 8'd0) latch_error(ST_ZERO_DOM);
                else move_to(PH_ADDR, b);
            end
            PH_ADDR: begin
                role = ROLE_ADDR;
                if (field_last()) move_to(PH_PORT, 8'd2);
            end
            PH_PORT: begin
                role = ROLE_PORT;
                dec_port = {dec_port[7:0], b};
                if (field_last()) address_done();
            end
            PH_PAYLOAD: begin
                role = ROLE_PAYLOAD;
                dec_paid = dec_paid + 17'd1;
                if (dec_paid >= {1'b0, dec_size}) move_to(PH_DONE, 8'd0);
            end
            default: begin
                role = ROLE_IGNORE;
            end
        endcase

        if (role <= ROLE_PORT) begin
            dec_hdr = dec_hdr + 10'd1;
        end

        r = '0;
        r.byte_role  = role;
        r.byte_value = b;
        if (last_flag) begin
            r.verdict_valid = 1'b1;
            r.status        = (dec_err == ST_OK && dec_phase != PH_DONE) ? ST_TRUNC : dec_err;
            r.command_code  = dec_cmd;
            r.assoc_num     = dec_assoc;
            r.packet_id     = dec_pktid;
            r.frag_count    = dec_ftot;
            r.frag_id       = dec_fid;
            r.data_size     = dec_size;
            r.port          = dec_port;
            r.header_length = dec_hdr;
            clear_frame_state();
        end
        return r;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic void queue_byte(input logic [7:0] b, input logic last_flag);
        t_frame_byte fb;
        fb.data = b;
        fb.last = last_flag;
        pending_bytes.push_back(fb);
    endfunction

    // flaw codes 86..88 give a bad address type, 89..91 a zero domain length
    function automatic void add_address(input int flaw, input bit in_packet);
        int r;
        int len;
        int i;
        r = $urandom_range(99);
        if (flaw >= 86 && flaw <= 88) begin
            if (in_packet) frame_buf.push_back(8'($urandom_range(3, 254)));
            else frame_buf.push_back(8'($urandom_range(3, 255)));
            return;
        end
        if (flaw >= 89 && flaw <= 91) begin
            frame_buf.push_back(AT_DOMAIN);
            frame_buf.push_back(8'd0);
            return;
        end
        if (in_packet && r >= 85) begin
            frame_buf.push_back(AT_NONE);
            return;
        end
        if (r < 35) begin
            len = (r < 3) ? 255 : $urandom_range(1, 12);
            frame_buf.push_back(AT_DOMAIN);
            frame_buf.push_back(8'(len));
        end else if (r < 65) begin
            len = int'(IPV4_BYTES);
            frame_buf.push_back(AT_IPV4);
        end else begin
            len = int'(IPV6_BYTES);
            frame_buf.push_back(AT_IPV6);
        end
        for (i = 0; i < len + 2; i++) begin
            frame_buf.push_back(rand_byte());
        end
    endfunction

    // Build one frame, mostly well-formed, and queue its bytes; returns the byte count.
    function automatic int build_frame();
        int          pick;
        int          flaw;
        int          r;
        int          n_pay;
        int          cut;
        int          i;
        logic [7:0]  cmd;
        logic [15:0] size;
        frame_buf.delete();
        pick = $urandom_range(99);
        flaw = $urandom_range(99);
        if (pick < 20) cmd = CMD_AUTH;
        else if (pick < 45) cmd = CMD_CONNECT;
        else if (pick < 85) cmd = CMD_PACKET;
        else if (pick < 93) cmd = CMD_DISSOC;
        else cmd = CMD_HEARTBEAT;
        frame_buf.push_back(ver_cfg);
        frame_buf.push_back(cmd);
        case (cmd)
            CMD_AUTH: begin
                for (i = 0; i < UUID_BYTES + tok_cfg; i++) frame_buf.push_back(rand_byte());
            end
            CMD_CONNECT: begin
                add_address(flaw, 1'b0);
            end
            CMD_PACKET: begin
                // association, packet id, fragment total and index
                repeat (6) frame_buf.push_back(rand_byte());
                r = $urandom_range(99);
                if (r < 15) size = 16'd0;
                else if (r < 85) size = 16'($urandom_range(1, 12));
                else if (r < 99) size = 16'($urandom_range(13, 64));
                else size = 16'($urandom_range(200, 400));
                n_pay = int'(size);
                // a frame that gets cut short may declare any size
                if (flaw >= 92 && flaw <= 95) begin
                    size  = 16'($urandom_range(65535));
                    n_pay = (size > 16'd24) ? 24 : int'(size);
                end
                frame_buf.push_back(size[15:8]);
                frame_buf.push_back(size[7:0]);
                add_address(flaw, 1'b1);
                for (i = 0; i < n_pay; i++) frame_buf.push_back(rand_byte());
            end
            CMD_DISSOC: begin
                repeat (2) frame_buf.push_back(rand_byte());
            end
            default: begin
            end
        endcase

        if (flaw >= 80 && flaw <= 82) begin
            frame_buf[0] = ver_cfg ^ 8'($urandom_range(1, 255));
        end else if (flaw >= 83 && flaw <= 85) begin
            frame_buf[1] = 8'($urandom_range(5, 255));
        end else if (flaw >= 92 && flaw <= 95) begin
            cut = int'($urandom_range(1, frame_buf.size() - 1));
            while (frame_buf.size() > cut) frame_buf.delete(frame_buf.size() - 1);
        end else if (flaw >= 96 && flaw <= 97) begin
            repeat ($urandom_range(1, 4)) frame_buf.push_back(rand_byte());
        end else if (flaw >= 98) begin
            frame_buf.delete();
            repeat ($urandom_range(1, 6)) frame_buf.push_back(rand_byte());
        end

        for (i = 0; i < frame_buf.size(); i++) begin
            queue_byte(frame_buf[i], i == frame_buf.size() - 1);
        end
        frames_built++;
        return frame_buf.size();
    endfunction

    task automatic check_field(input string name, input logic [15:0] want_v, got_v);
        if (got_v !== want_v) begin
            if (fault_count < 10) begin
                $display("result %0d: %s expected %0h got %0h", results_seen, name, want_v, got_v);
            end
            fault_count++;
        end
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        if (idx == CFG_VERSION) ver_cfg = value;
        else tok_cfg = value[6:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_for_idle();
        while (pending_bytes.size() != 0 || expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic run_phase(input bit write_regs, input logic [7:0] ver, input logic [6:0] tok,
                             input int send_pct, input int stall_pct, input int n_items,
                             input t_pressure pressure);
        int added;
        added = 0;
        if (write_regs) begin
            write_reg(CFG_VERSION, ver);
            write_reg(CFG_TOKEN, {1'b0, tok});
        end
        @(negedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        while (added < n_items / 2) added += build_frame();
        if (pressure == PRESS_HOLD) hold_asks++;
        // let everything drain before the second half is queued
        if (pressure == PRESS_PAUSE) wait_for_idle();
        while (added < n_items) added += build_frame();
        wait_for_idle();
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // sender: offer queued bytes, hold an offered item until it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_results.push_back(decode_byte(in_ch.data_byte, in_ch.last_byte));
                pending_bytes.delete(0);
                bytes_sent++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_ch.valid     <= 1'b1;
                    in_ch.data_byte <= pending_bytes[0].data;
                    in_ch.last_byte <= pending_bytes[0].last;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each result, stall at random or for a long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    if (fault_count < 10) begin
                        $display("result %0d: no result expected, got role %0d value %0h",
                                 results_seen, out_ch.byte_role, out_ch.byte_value);
                    end
                    fault_count++;
                end else begin
                    oldest = expected_results[0];
                    expected_results.delete(0);
                    if (oldest.verdict_valid) verdicts_seen++;
                    check_field("byte_role", 16'(oldest.byte_role), 16'(out_ch.byte_role));
                    check_field("byte_value", 16'(oldest.byte_value), 16'(out_ch.byte_value));
                    check_field("verdict_valid", 16'(oldest.verdict_valid),
                                16'(out_ch.verdict_valid));
                    check_field("status", 16'(oldest.status), 16'(out_ch.status));
                    check_field("command_code", 16'(oldest.command_code),
                                16'(out_ch.command_code));
                    check_field("assoc_num", oldest.assoc_num, out_ch.assoc_num);
                    check_field("packet_id", oldest.packet_id, out_ch.packet_id);
                    check_field("frag_count", 16'(oldest.frag_count), 16'(out_ch.frag_count));
                    check_field("frag_id", 16'(oldest.frag_id), 16'(out_ch.frag_id));
                    check_field("data_size", oldest.data_size, out_ch.data_size);
                    check_field("port", oldest.port, out_ch.port);
                    check_field("header_length", 16'(oldest.header_length),
                                16'(out_ch.header_length));
                end
            end
            if (hold_served != hold_asks) begin
                hold_served  <= hold_asks;
                hold_left    <= LONG_HOLD;
                out_ch.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [7:0] rnd_ver;
        logic [6:0] rnd_tok;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_VERSION;
        i_cfg_data      = 8'd0;
        ver_cfg         = VERSION_RESET;
        tok_cfg         = TOKEN_RESET;
        clear_frame_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // shortest valid frame
        queue_byte(VERSION_RESET, 1'b0);
        queue_byte(CMD_HEARTBEAT, 1'b1);
        // dissociate, all-ones association id
        queue_byte(VERSION_RESET, 1'b0);
        queue_byte(CMD_DISSOC, 1'b0);
        queue_byte(8'hff, 1'b0);
        queue_byte(8'hff, 1'b1);
        // version mismatch on a lone zero byte
        queue_byte(8'h00, 1'b1);
        // unknown command, largest code
        queue_byte(VERSION_RESET, 1'b0);
        queue_byte(8'hff, 1'b1);
        // address type none outside a packet frame
        queue_byte(VERSION_RESET, 1'b0);
        queue_byte(CMD_CONNECT, 1'b0);
        queue_byte(AT_NONE, 1'b1);
        // zero domain length
        queue_byte(VERSION_RESET, 1'b0);
        queue_byte(CMD_CONNECT, 1'b0);
        queue_byte(AT_DOMAIN, 1'b0);
        queue_byte(8'h00, 1'b1);
        // buffer ends inside the association id
        queue_byte(VERSION_RESET, 1'b0);
        queue_byte(CMD_PACKET, 1'b0);
        queue_byte(8'h12, 1'b1);
        // extra byte after a complete frame
        queue_byte(VERSION_RESET, 1'b0);
        queue_byte(CMD_HEARTBEAT, 1'b0);
        queue_byte(8'haa, 1'b1);
        // first error wins over the bytes after it
        queue_byte(VERSION_RESET, 1'b0);
        queue_byte(8'h07, 1'b0);
        queue_byte(CMD_CONNECT, 1'b0);
        queue_byte(8'h01, 1'b1);

        run_phase(1'b0, VERSION_RESET, TOKEN_RESET, 0, 0, 200, PRESS_HOLD);
        run_phase(1'b1, 8'd0, 7'd1, 71, 0, 300, PRESS_NONE);
        run_phase(1'b1, 8'd255, 7'd64, 0, 71, 300, PRESS_NONE);
        rnd_ver = 8'($urandom_range(255));
        run_phase(1'b1, rnd_ver, 7'd0, 26, 26, 250, PRESS_NONE);
        rnd_tok = 7'($urandom_range(1, 64));
        run_phase(1'b1, VERSION_RESET, rnd_tok, 0, 0, 300, PRESS_PAUSE);
        rnd_ver = 8'($urandom_range(255));
        rnd_tok = 7'($urandom_range(1, 64));
        run_phase(1'b1, rnd_ver, rnd_tok, 26, 26, 300, PRESS_HOLD);
        run_phase(1'b1, VERSION_RESET, TOKEN_RESET, 0, 71, 300, PRESS_NONE);

        repeat (8) @(posedge i_clk);
        $display("sent %0d bytes in %0d random frames plus directed cases; checked %0d results",
                 bytes_sent, frames_built, results_seen);
        $display("%0d frame verdicts over 7 register settings, %0d field faults",
                 verdicts_seen, fault_count);
        if (fault_count == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
